// ----- design/multi_stack_shared_store_assert.svh -----
// Assertion macros for the shared-store stack block.
// Used by multi_stack_shared_store.sv; expects i_clk and i_rst_n in scope.
`ifndef MULTI_STACK_SHARED_STORE_ASSERT_SVH
`define MULTI_STACK_SHARED_STORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// condition holds on every edge out of reset
`define MSS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
// same-cycle implication
`define MSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MSS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MSS_ASSERT_ALWAYS(lbl, cond, msg)
`define MSS_ASSERT_IMP(lbl, ante, cons, msg)
`define MSS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/mss_pkg.sv -----
// Shared types and codes for the multi-stack shared store.
// No dependencies; imported by mss_store and multi_stack_shared_store.
package mss_pkg;

    typedef enum logic [1:0] {
        KIND_PUSH = 2'd0,
        KIND_POP  = 2'd1,
        KIND_PEEK = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         stack_id;
        logic signed [31:0] value;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         status;
    } t_out_rsp;

    // control from the request stage to the slot memories
    typedef struct packed {
        logic rd_en;
        logic link_we;
        logic elem_we;
    } t_store_ctl;

endpackage

// ----- design/mss_store.sv -----
// Element and link memories with registered read and write-to-read bypass.
// Depends on mss_pkg. Untouched link entries read as their reset value
// (slot + 1) by comparing against the fill count.
module mss_store import mss_pkg::*; #(
    parameter int CAPACITY = 16,
    parameter int PW       = 5,
    parameter int AW       = 4
) (
    input  logic             i_clk,
    input  t_store_ctl       i_ctl,
    input  logic [PW-1:0]    i_rd_ptr,
    input  logic [PW-1:0]    i_fill,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [PW-1:0]    i_wr_link,
    input  logic [31:0]      i_wr_elem,
    output logic [PW-1:0]    o_link,
    output logic [31:0]      o_elem
);

    logic [PW-1:0] r_link_mem [CAPACITY];
    logic [31:0]   r_elem_mem [CAPACITY];

    logic [PW-1:0] r_link_q;
    logic [31:0]   r_elem_q;
    logic          r_link_byp;
    logic          r_elem_byp;
    logic [PW-1:0] r_link_wd;
    logic [31:0]   r_elem_wd;
    logic          r_dflt;
    logic [PW-1:0] r_dflt_val;

    logic [AW-1:0] w_rd_addr;

    assign w_rd_addr = i_rd_ptr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.link_we) begin
            r_link_mem[i_wr_addr] <= i_wr_link;
        end
        if (i_ctl.elem_we) begin
            r_elem_mem[i_wr_addr] <= i_wr_elem;
        end
    end

    // read port; the write in the same cycle is forwarded
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_link_q   <= r_link_mem[w_rd_addr];
            r_elem_q   <= r_elem_mem[w_rd_addr];
            r_link_byp <= i_ctl.link_we && (i_wr_addr == w_rd_addr);
            r_elem_byp <= i_ctl.elem_we && (i_wr_addr == w_rd_addr);
            r_link_wd  <= i_wr_link;
            r_elem_wd  <= i_wr_elem;
            r_dflt     <= (i_rd_ptr >= i_fill);
            r_dflt_val <= i_rd_ptr + PW'(1);
        end
    end

    assign o_link = r_link_byp ? r_link_wd : (r_dflt ? r_dflt_val : r_link_q);
    assign o_elem = r_elem_byp ? r_elem_wd : r_elem_q;

endmodule

// ----- design/multi_stack_shared_store.sv -----
// Top level: several stacks threaded through one shared slot store with a free list.
// Depends on mss_pkg, mss_store and multi_stack_shared_store_assert.svh.
//
//   channel | valid      | stall       | payload
//   request | i_in_valid | o_in_stall  | i_req  (kind, stack_id, value)
//   response| o_out_valid| i_out_stall | o_rsp  (data, status)
//
// One request per cycle sustained while the response is not stalled; a request
// passes through the request stage register and then the response register.
// Slot memories are read at acceptance, pointers and links update when the request commits.
// Reset is synchronous; no clearing pass: a fill count stands in for link reset values.
// A stalled response holds the request stage, which in turn stalls new requests.
`include "multi_stack_shared_store_assert.svh"

module multi_stack_shared_store import mss_pkg::*; #(
    parameter int CAPACITY   = 16,
    parameter int NUM_STACKS = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_rsp o_rsp
);

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam logic [PW-1:0] NIL = PW'(CAPACITY);

    // stack number folded into range by compare and subtract
    function automatic logic [SW-1:0] fold_sid(input logic [1:0] sid);
        int v;
        v = int'(sid);
        for (int k = 0; k < 3; k++) begin
            if (v >= NUM_STACKS) begin
                v = v - NUM_STACKS;
            end
        end
        return SW'(v);
    endfunction

    // request stage
    logic               r_req_v;
    logic [1:0]         r_kind;
    logic [SW-1:0]      r_sid;
    logic signed [31:0] r_value;
    logic [PW-1:0]      r_top;

    // stack state
    logic [PW-1:0]      r_tops [NUM_STACKS];
    logic [PW-1:0]      r_free_head;
    logic [PW-1:0]      r_fill;

    // response register
    logic               r_out_v;
    t_out_rsp           r_out;

    logic               w_adv;
    logic               w_commit;
    logic               w_accept;
    logic [PW-1:0]      w_link;
    logic [31:0]        w_elem;
    logic               w_push_ok;
    logic               w_pop_ok;
    logic               w_top_we;
    logic [PW-1:0]      w_top_new;
    logic [PW-1:0]      n_free_head;
    logic [PW-1:0]      n_fill;
    logic [AW-1:0]      w_wr_addr;
    logic [PW-1:0]      w_wr_link;
    t_out_rsp           w_rsp;
    logic [PW-1:0]      w_fh_next;
    logic [PW-1:0]      w_fill_next;
    logic [SW-1:0]      w_in_sid;
    logic [PW-1:0]      w_in_top;
    logic [PW-1:0]      w_rd_ptr;
    t_store_ctl         w_ctl;

    assign w_adv      = !r_out_v || !i_out_stall;
    assign w_commit   = r_req_v && w_adv;
    assign o_in_stall = r_req_v && !w_adv;
    assign w_accept   = i_in_valid && !o_in_stall;

    // request stage: pointer update and response
    always_comb begin
        w_push_ok   = 1'b0;
        w_pop_ok    = 1'b0;
        w_top_we    = 1'b0;
        w_top_new   = r_top;
        n_free_head = r_free_head;
        n_fill      = r_fill;
        w_wr_addr   = r_free_head[AW-1:0];
        w_wr_link   = NIL;
        w_rsp       = '{data: '0, status: ST_OK};
        unique case (r_kind)
            KIND_PUSH: begin
                if (r_free_head >= NIL) begin
                    w_rsp.status = ST_OVERFLOW;
                end else begin
                    w_push_ok   = 1'b1;
                    w_top_we    = 1'b1;
                    w_top_new   = r_free_head;
                    n_free_head = (w_link < NIL) ? w_link : NIL;
                    w_wr_addr   = r_free_head[AW-1:0];
                    w_wr_link   = (r_top < NIL) ? r_top : NIL;
                    if (r_free_head == r_fill) begin
                        n_fill = r_fill + PW'(1);
                    end
                end
            end
            KIND_POP: begin
                if (r_top >= NIL) begin
                    w_rsp.status = ST_UNDERFLOW;
                end else begin
                    w_pop_ok    = 1'b1;
                    w_top_we    = 1'b1;
                    w_top_new   = (w_link < NIL) ? w_link : NIL;
                    n_free_head = r_top;
                    w_wr_addr   = r_top[AW-1:0];
                    w_wr_link   = (r_free_head < NIL) ? r_free_head : NIL;
                    w_rsp.data  = w_elem;
                end
            end
            KIND_PEEK: begin
                if (r_top >= NIL) begin
                    w_rsp.status = ST_UNDERFLOW;
                end else begin
                    w_rsp.data = w_elem;
                end
            end
            default: begin
                w_rsp.status = ST_OK;
            end
        endcase
    end

    // read address for the incoming request sees this cycle's update
    assign w_fh_next   = w_commit ? n_free_head : r_free_head;
    assign w_fill_next = w_commit ? n_fill : r_fill;
    assign w_in_sid    = fold_sid(i_req.stack_id);
    assign w_in_top    = (w_commit && w_top_we && (r_sid == w_in_sid)) ? w_top_new
                                                                      : r_tops[w_in_sid];
    assign w_rd_ptr    = (i_req.kind == KIND_PUSH) ? w_fh_next : w_in_top;

    assign w_ctl.rd_en   = w_accept;
    assign w_ctl.link_we = w_commit && (w_push_ok || w_pop_ok);
    assign w_ctl.elem_we = w_commit && w_push_ok;

    mss_store #(
        .CAPACITY (CAPACITY),
        .PW       (PW),
        .AW       (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_rd_ptr  (w_rd_ptr),
        .i_fill    (w_fill_next),
        .i_wr_addr (w_wr_addr),
        .i_wr_link (w_wr_link),
        .i_wr_elem (r_value),
        .o_link    (w_link),
        .o_elem    (w_elem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_v <= 1'b0;
        end else if (!o_in_stall) begin
            r_req_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_req.kind;
            r_sid   <= w_in_sid;
            r_value <= i_req.value;
            r_top   <= w_in_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_STACKS; i++) begin
                r_tops[i] <= NIL;
            end
            r_free_head <= '0;
            r_fill      <= '0;
        end else if (w_commit) begin
            if (w_top_we) begin
                r_tops[r_sid] <= w_top_new;
            end
            r_free_head <= n_free_head;
            r_fill      <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= r_req_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out <= w_rsp;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_rsp       = r_out;

    `MSS_ASSERT_ALWAYS(a_fill_range, r_fill <= NIL, "fill count beyond capacity")
    `MSS_ASSERT_IMP(a_free_nonempty, r_fill != NIL, r_free_head < NIL, "free list empty")
    `MSS_ASSERT_NXT(a_commit_rsp, w_commit, r_out_v, "committed request gave no response")
    `MSS_ASSERT_NXT(a_push_head, w_commit && w_push_ok,
                    r_tops[$past(r_sid)] == $past(r_free_head), "push missed free head")

endmodule
